@@ sv/slp_pkg.sv @@
// slp_pkg: field widths, schedule kinds and status codes shared by the
// loop partitioner modules. No dependencies.
package slp_pkg;

  localparam int FIELD_W = 64;
  localparam int RANK_W  = 8;
  localparam int OP_W    = 2;
  localparam int CFG_W   = 9;
  localparam int STAT_W  = 2;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [CFG_W-1:0]   cfg_t;
  typedef logic [STAT_W-1:0]  stat_t;

  // schedule kinds; the two spare codes are unsupported
  localparam op_t OP_BALANCED = 2'd0;
  localparam op_t OP_CHUNKED  = 2'd1;
  localparam op_t OP_SPARE2   = 2'd2;
  localparam op_t OP_SPARE3   = 2'd3;

  // result status
  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_BAD_SCHED = 2'd1;
  localparam stat_t ST_ZERO_INC  = 2'd2;

endpackage

@@ sv/slp_div.sv @@
// slp_div: pipelined restoring divider, one quotient bit per stage, with a
// sideband word carried alongside. Standalone, no package needed.
module slp_div #(
  parameter int W  = 64,
  parameter int DW = 64,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [W-1:0]  quot,
  output logic [DW-1:0] rem,
  output logic [PW-1:0] out_pay
);

  logic [W:0]    vld_s;
  logic [DW-1:0] rem_s [0:W];
  logic [W-1:0]  wrk_s [0:W];
  logic [DW-1:0] dvs_s [0:W];
  logic [PW-1:0] pay_s [0:W];

  // stage zero is the incoming operand set
  assign vld_s[0] = in_valid;
  assign rem_s[0] = '0;
  assign wrk_s[0] = dividend;
  assign dvs_s[0] = divisor;
  assign pay_s[0] = in_pay;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_s[i], wrk_s[i][W-1]};
    assign ge    = (trial >= {1'b0, dvs_s[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (en) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? DW'(trial - {1'b0, dvs_s[i]}) : trial[DW-1:0];
        wrk_s[i+1] <= {wrk_s[i][W-2:0], ge};
        dvs_s[i+1] <= dvs_s[i];
        pay_s[i+1] <= pay_s[i];
      end
    end
  end

  assign out_valid = vld_s[W];
  assign quot      = wrk_s[W];
  assign rem       = rem_s[W];
  assign out_pay   = pay_s[W];

endmodule

@@ sv/slp_mul.sv @@
// slp_mul: two-stage pair of low-half multipliers sharing one operand,
// built from half-width partial products. Standalone, no package needed.
module slp_mul #(
  parameter int W  = 64,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  a1,
  input  logic [W-1:0]  a2,
  input  logic [W-1:0]  b,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [W-1:0]  x1,
  output logic [W-1:0]  x2,
  output logic [PW-1:0] out_pay
);

  localparam int H = W / 2;
  localparam int L = W - H;

  logic [2*H-1:0] pll1, pll2;
  logic [L-1:0]   crs1, crs2;
  logic           v1, v2;
  logic [PW-1:0]  pay1;

  // partial products: low by low in full, cross terms only where they land
  always_ff @(posedge clk) begin
    if (en) begin
      pll1 <= (2*H)'(a1[H-1:0]) * (2*H)'(b[H-1:0]);
      pll2 <= (2*H)'(a2[H-1:0]) * (2*H)'(b[H-1:0]);
      crs1 <= L'(a1[H-1:0] * b[W-1:H]) + L'(a1[W-1:H] * b[H-1:0]);
      crs2 <= L'(a2[H-1:0] * b[W-1:H]) + L'(a2[W-1:H] * b[H-1:0]);
      pay1 <= in_pay;
    end
  end

  // combine partials
  always_ff @(posedge clk) begin
    if (en) begin
      x1      <= W'(pll1) + {crs1, H'(0)};
      x2      <= W'(pll2) + {crs2, H'(0)};
      out_pay <= pay1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  assign out_valid = v2;

endmodule

@@ sv/static_loop_partitioner.sv @@
// Pipeline: request register, four bit-per-stage dividers in a row (trip
// count, share, chunk index, owner rank), multiplier, output register.
// Throughput: one request per cycle; the whole pipe holds while a result
// waits with out_stall high, and in_stall follows that condition.
// Reset (synchronous, rst high): clears all valid bits and sets
// thread_count to 1.
module static_loop_partitioner #(
  parameter int MAX_THREADS = 256,
  parameter int INDEX_WIDTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  slp_pkg::cfg_t   cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  slp_pkg::op_t    operation,
  input  slp_pkg::rank_t  thread_rank,
  input  slp_pkg::field_t lower_bound,
  input  slp_pkg::field_t upper_bound,
  input  slp_pkg::field_t increment,
  input  slp_pkg::field_t chunk_len,
  output logic            out_valid,
  input  logic            out_stall,
  output slp_pkg::field_t new_lower,
  output slp_pkg::field_t new_upper,
  output slp_pkg::field_t stride,
  output logic            is_last,
  output slp_pkg::stat_t  status
);
  import slp_pkg::*;

  localparam int IW = INDEX_WIDTH;
  localparam int NW = $clog2(MAX_THREADS + 1);

  typedef struct packed {
    op_t           op;
    rank_t         rank;
    logic [IW-1:0] lo;
    logic [IW-1:0] up;
    logic [IW-1:0] inc;
    logic [IW-1:0] chk;
    logic [NW-1:0] n;
    logic          empty;
    logic          byp;
    logic [IW-1:0] bst;
    logic          blast;
    stat_t         stat;
  } ctx_t;

  typedef struct packed {
    ctx_t          ctx;
    logic [IW-1:0] q;
  } d1_t;

  typedef struct packed {
    d1_t           d;
    logic [IW-1:0] a;
    logic [NW-1:0] r;
  } d2_t;

  typedef struct packed {
    ctx_t          ctx;
    logic [IW-1:0] per;
    logic [NW-1:0] extras;
    logic [IW-1:0] m;
    logic          few;
    logic          nowork;
    logic          last_bal;
    logic          last_chk;
  } p1_t;

  typedef struct packed {
    p1_t           p;
    logic [IW-1:0] x1;
    logic [IW-1:0] x2;
    logic [IW-1:0] sr;
    logic [IW-1:0] sn;
  } p3_t;

  logic en;
  cfg_t thread_cnt;

  // whole pipe advances unless the output holds an untaken result
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // thread count register
  always_ff @(posedge clk) begin
    if (rst) begin
      thread_cnt <= CFG_W'(1);
    end else if (cfg_write) begin
      thread_cnt <= cfg_data;
    end
  end

  // capture the request
  logic          a_valid;
  op_t           a_op;
  rank_t         a_rank;
  logic [IW-1:0] a_lo, a_up, a_inc, a_chk;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= operation;
      a_rank <= thread_rank;
      a_lo   <= lower_bound[IW-1:0];
      a_up   <= upper_bound[IW-1:0];
      a_inc  <= increment[IW-1:0];
      a_chk  <= chunk_len[IW-1:0];
    end
  end

  // classify the loop and set up the trip count division
  ctx_t          ctx;
  logic [31:0]   cnt32;
  logic [31:0]   nsel;
  logic          pos;
  logic [IW-1:0] mag, diff, dvd1;

  always_comb begin
    cnt32 = 32'(thread_cnt);
    if (cnt32 == 32'd0) begin
      nsel = 32'd1;
    end else if (cnt32 > 32'(MAX_THREADS)) begin
      nsel = 32'(MAX_THREADS);
    end else begin
      nsel = cnt32;
    end

    pos  = !a_inc[IW-1];
    mag  = pos ? a_inc : (IW'(0) - a_inc);
    diff = pos ? (a_up - a_lo) : (a_lo - a_up);

    ctx.op    = a_op;
    ctx.rank  = a_rank;
    ctx.lo    = a_lo;
    ctx.up    = a_up;
    ctx.inc   = a_inc;
    ctx.chk   = (a_chk[IW-1] || (a_chk == '0)) ? IW'(1) : a_chk;
    ctx.n     = nsel[NW-1:0];
    ctx.empty = pos ? ($signed(a_up) < $signed(a_lo)) : ($signed(a_lo) < $signed(a_up));

    if (a_inc == '0) begin
      ctx.stat = ST_ZERO_INC;
    end else if (a_op != OP_BALANCED && a_op != OP_CHUNKED) begin
      ctx.stat = ST_BAD_SCHED;
    end else begin
      ctx.stat = ST_OK;
    end

    ctx.blast = (ctx.stat == ST_OK) && (nsel == 32'd1);
    ctx.byp   = (ctx.stat != ST_OK) || (nsel == 32'd1);
    if (ctx.blast) begin
      ctx.bst = pos ? (a_up - a_lo + IW'(1)) : (a_up - a_lo - IW'(1));
    end else begin
      ctx.bst = '0;
    end

    dvd1 = ctx.empty ? '0 : diff;
  end

  // trip count minus one
  logic          d1_valid;
  logic [IW-1:0] d1_q;
  ctx_t          d1_ctx;

  slp_div #(.W(IW), .DW(IW), .PW($bits(ctx_t))) u_div_trip (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_valid), .dividend(dvd1), .divisor(mag), .in_pay(ctx),
    .out_valid(d1_valid), .quot(d1_q), .rem(), .out_pay(d1_ctx)
  );

  d1_t d1;
  assign d1.ctx = d1_ctx;
  assign d1.q   = d1_q;

  // share per thread and remainder
  logic          d2_valid;
  logic [IW-1:0] d2_a;
  logic [NW-1:0] d2_r;
  d1_t           d2_d;

  slp_div #(.W(IW), .DW(NW), .PW($bits(d1_t))) u_div_share (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .dividend(d1.q), .divisor(d1.ctx.n), .in_pay(d1),
    .out_valid(d2_valid), .quot(d2_a), .rem(d2_r), .out_pay(d2_d)
  );

  d2_t d2;
  assign d2.d = d2_d;
  assign d2.a = d2_a;
  assign d2.r = d2_r;

  // chunk index of the final iteration
  logic          d3_valid;
  logic [IW-1:0] d3_qc;
  d2_t           d3;

  slp_div #(.W(IW), .DW(IW), .PW($bits(d2_t))) u_div_chunk (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d2_valid), .dividend(d2.d.q), .divisor(d2.d.ctx.chk), .in_pay(d2),
    .out_valid(d3_valid), .quot(d3_qc), .rem(), .out_pay(d3)
  );

  // owner rank of the final chunk
  logic          d4_valid;
  logic [NW-1:0] d4_own;
  d2_t           d4;

  slp_div #(.W(IW), .DW(NW), .PW($bits(d2_t))) u_div_owner (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d3_valid), .dividend(d3_qc), .divisor(d3.d.ctx.n), .in_pay(d3),
    .out_valid(d4_valid), .quot(), .rem(d4_own), .out_pay(d4)
  );

  // balanced share sizes and last-iteration flags
  p1_t           p1_next, p1;
  logic          p1_valid;
  logic [NW:0]   rp1;
  logic          wrap;
  logic [IW-1:0] rank_w;

  always_comb begin
    rank_w = IW'(d4.d.ctx.rank);
    rp1    = {1'b0, d4.r} + (NW+1)'(1);
    wrap   = (rp1 == {1'b0, d4.d.ctx.n});

    p1_next.ctx      = d4.d.ctx;
    p1_next.per      = wrap ? (d4.a + IW'(1)) : d4.a;
    p1_next.extras   = wrap ? '0 : rp1[NW-1:0];
    p1_next.m        = IW'(rank_w * p1_next.per);
    p1_next.few      = (d4.d.q < IW'(d4.d.ctx.n));
    p1_next.nowork   = d4.d.ctx.empty || ((rank_w > d4.d.q) && p1_next.few);
    p1_next.last_bal = !p1_next.nowork &&
                       (p1_next.few ? (rank_w == d4.d.q)
                                    : (rank_w == IW'(d4.d.ctx.n) - IW'(1)));
    p1_next.last_chk = !d4.d.ctx.empty && (32'(d4.d.ctx.rank) == 32'(d4_own));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= d4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= p1_next;
    end
  end

  // iteration offsets of the first and last index; chunk span when chunked
  logic          rlt;
  logic [IW-1:0] rk, ex, kk, kk2, ma1, ma2;

  always_comb begin
    rk  = IW'(p1.ctx.rank);
    ex  = IW'(p1.extras);
    rlt = (rk < ex);
    kk  = p1.m + (rlt ? rk : ex);
    kk2 = kk + p1.per + IW'(rlt) - IW'(1);
    if (p1.ctx.op == OP_CHUNKED) begin
      ma1 = p1.ctx.chk;
    end else begin
      ma1 = p1.few ? rk : kk;
    end
    ma2 = p1.few ? rk : kk2;
  end

  logic          m_valid;
  logic [IW-1:0] m_x1, m_x2;
  p1_t           m_p;

  slp_mul #(.W(IW), .PW($bits(p1_t))) u_mul (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(p1_valid), .a1(ma1), .a2(ma2), .b(p1.ctx.inc), .in_pay(p1),
    .out_valid(m_valid), .x1(m_x1), .x2(m_x2), .out_pay(m_p)
  );

  // chunk offsets and stride
  p3_t  p3;
  logic p3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3.p  <= m_p;
      p3.x1 <= m_x1;
      p3.x2 <= m_x2;
      p3.sr <= IW'(m_x1 * IW'(m_p.ctx.rank));
      p3.sn <= IW'(m_x1 * IW'(m_p.ctx.n));
    end
  end

  // final bounds
  logic [IW-1:0] nl_next, nu_next, st_next;
  logic          last_next;
  logic [IW-1:0] nl, nu, st;

  always_comb begin
    if (p3.p.ctx.byp) begin
      nl_next   = p3.p.ctx.lo;
      nu_next   = p3.p.ctx.up;
      st_next   = p3.p.ctx.bst;
      last_next = p3.p.ctx.blast;
    end else if (p3.p.ctx.op == OP_BALANCED) begin
      st_next = '0;
      if (p3.p.nowork) begin
        nl_next   = p3.p.ctx.up + p3.p.ctx.inc;
        nu_next   = p3.p.ctx.up;
        last_next = 1'b0;
      end else begin
        nl_next   = p3.p.ctx.lo + p3.x1;
        nu_next   = p3.p.ctx.lo + p3.x2;
        last_next = p3.p.last_bal;
      end
    end else begin
      nl_next   = p3.p.ctx.lo + p3.sr;
      nu_next   = p3.p.ctx.lo + p3.sr + p3.x1 - p3.p.ctx.inc;
      st_next   = p3.sn;
      last_next = p3.p.last_chk;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl      <= nl_next;
      nu      <= nu_next;
      st      <= st_next;
      is_last <= last_next;
      status  <= p3.p.ctx.stat;
    end
  end

  assign new_lower = FIELD_W'(signed'(nl));
  assign new_upper = FIELD_W'(signed'(nu));
  assign stride    = FIELD_W'(signed'(st));

  // checks
  a_rst_count: assert property (@(posedge clk) rst |=> thread_cnt == CFG_W'(1))
    else $error("thread count not restored by reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result is held");

  a_zero_inc: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ZERO_INC |-> !is_last && stride == '0)
    else $error("zero increment result carries stride or last flag");

  a_bad_sched: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_SCHED |-> !is_last && stride == '0)
    else $error("unsupported schedule result carries stride or last flag");

endmodule

@@ verif/slp_checker.sv @@
// slp_checker: watches the request and result channels of the loop
// partitioner, predicts each result and compares it. Depends on slp_pkg.
`timescale 1ns / 100ps

module slp_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  slp_pkg::cfg_t   cfg_data,
  input  logic            in_valid,
  input  logic            in_stall,
  input  slp_pkg::op_t    operation,
  input  slp_pkg::rank_t  thread_rank,
  input  slp_pkg::field_t lower_bound,
  input  slp_pkg::field_t upper_bound,
  input  slp_pkg::field_t increment,
  input  slp_pkg::field_t chunk_len,
  input  logic            out_valid,
  input  logic            out_stall,
  input  slp_pkg::field_t new_lower,
  input  slp_pkg::field_t new_upper,
  input  slp_pkg::field_t stride,
  input  logic            is_last,
  input  slp_pkg::stat_t  status,
  output int              fail_count,
  output int              pending,
  output int              share_count
);
  import slp_pkg::*;

  typedef struct packed {
    field_t lo;
    field_t up;
    field_t st;
    logic   last;
    stat_t  stat;
  } share_t;

  localparam int MAX_THREADS = 256;

  share_t      share_q[$];
  logic [8:0]  threads;

  // signed less-than on raw 64-bit words
  function automatic logic sless(field_t a, field_t b);
    return $signed(a) < $signed(b);
  endfunction

  // compute one thread's share of the loop
  function automatic share_t compute_share(op_t op, rank_t rk_in, field_t lo,
                                           field_t up, field_t inc, field_t chk,
                                           logic [8:0] cnt);
    share_t s;
    field_t n, rk, mag, q, a, r, per, extras, v, base, c, span;
    logic   pos, empty;
    n  = cnt;
    rk = rk_in;
    if (n == 0) n = 1;
    if (n > MAX_THREADS) n = MAX_THREADS;
    s = '0;
    s.lo = lo;
    s.up = up;
    if (inc == 0) begin
      s.stat = ST_ZERO_INC;
      return s;
    end
    if (op != OP_BALANCED && op != OP_CHUNKED) begin
      s.stat = ST_BAD_SCHED;
      return s;
    end
    s.stat = ST_OK;
    pos = !sless(inc, 0);
    if (n == 1) begin
      s.st = pos ? up - lo + 1 : up - lo - 1;
      s.last = 1'b1;
      return s;
    end
    mag = pos ? inc : -inc;
    empty = pos ? sless(up, lo) : sless(lo, up);
    q = empty ? 64'd0 : (pos ? (up - lo) / mag : (lo - up) / mag);
    if (op == OP_BALANCED) begin
      if ((empty || rk > q) && (empty || q < n)) begin
        s.lo = up + inc;
        return s;
      end
      if (q < n) begin
        v = lo + rk * inc;
        s.lo = v;
        s.up = v;
        s.last = (rk == q);
        return s;
      end
      a = q / n;
      r = q % n;
      if (r + 1 == n) begin
        per = a + 1;
        extras = 0;
      end else begin
        per = a;
        extras = r + 1;
      end
      if (rk < extras) begin
        s.up = lo + (rk + 1) * (per + 1) * inc - inc;
        s.lo = lo + rk * (per + 1) * inc;
      end else begin
        base = lo + extras * (per + 1) * inc;
        s.up = base + (rk + 1 - extras) * per * inc - inc;
        s.lo = base + (rk - extras) * per * inc;
      end
      s.last = (rk == n - 1);
      return s;
    end
    c = sless(chk, 1) ? 64'd1 : chk;
    span = c * inc;
    s.lo = lo + span * rk;
    s.up = s.lo + span - inc;
    s.st = span * n;
    s.last = !empty && (rk == (q / c) % n);
    return s;
  endfunction

  assign pending = share_q.size();

  // track config, queue predictions on request transfers, compare results
  always @(posedge clk) begin
    share_t exp_s;
    share_t got;
    if (rst) begin
      threads <= 9'd1;
      share_q.delete();
      fail_count <= 0;
      share_count <= 0;
    end else begin
      if (cfg_write) threads <= cfg_data;
      if (in_valid && !in_stall)
        share_q.push_back(compute_share(operation, thread_rank, lower_bound,
                                        upper_bound, increment, chunk_len,
                                        threads));
      if (out_valid && !out_stall) begin
        got = '{new_lower, new_upper, stride, is_last, status};
        share_count <= share_count + 1;
        if (share_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transfer %p", got);
        end else begin
          exp_s = share_q.pop_front();
          if (got !== exp_s) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %p got %p", exp_s, got);
          end
        end
      end
    end
  end
endmodule

@@ verif/tb.sv @@
// tb: stimulus and verdict for static_loop_partitioner; instantiates the
// block and slp_checker. Depends on slp_pkg.
`timescale 1ns / 100ps

module tb;
  import slp_pkg::*;

  localparam int LATENCY = 4 * 64 + 6;
  localparam int LIMIT   = 400000;

  logic   clk = 0;
  logic   rst = 1;
  logic   cfg_write = 0;
  cfg_t   cfg_data = '0;
  logic   in_valid = 0;
  logic   in_stall;
  op_t    operation = OP_BALANCED;
  rank_t  thread_rank = '0;
  field_t lower_bound = '0, upper_bound = '0, increment = '0, chunk_len = '0;
  logic   out_valid;
  logic   out_stall = 0;
  field_t new_lower, new_upper, stride;
  logic   is_last;
  stat_t  status;
  int     fail_count, pending, share_count;
  int     cycles = 0;
  int     send_idle = 0, recv_idle = 0;
  int     sent = 0;
  cfg_t   cur_threads = 9'd1;

  always #4 clk = ~clk;

  static_loop_partitioner dut (
    .clk, .rst, .cfg_write, .cfg_data, .in_valid, .in_stall, .operation,
    .thread_rank, .lower_bound, .upper_bound, .increment, .chunk_len,
    .out_valid, .out_stall, .new_lower, .new_upper, .stride, .is_last, .status
  );

  slp_checker chk (.*);

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall at the falling edge
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_idle);

  // pick a 64-bit value, biased toward small and edge values
  function automatic field_t pick_index();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'h8000_0000_0000_0000 + $urandom_range(3);
      2: return 64'h7fff_ffff_ffff_ffff - $urandom_range(3);
      default: return field_t'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  // hold one request until its transfer; valid drops only on idle cycles
  task automatic send(op_t op, rank_t rk, field_t lo, field_t up, field_t inc,
                      field_t cs);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    operation <= op;
    thread_rank <= rk;
    lower_bound <= lo;
    upper_bound <= up;
    increment <= inc;
    chunk_len <= cs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // write thread_count once the block has drained
  task automatic set_threads(cfg_t n);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_write <= 1;
    cfg_data <= n;
    cur_threads = n;
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // random requests, mostly well-formed loops with valid ranks
  task automatic random_run(int count);
    field_t lo, inc, cs;
    rank_t  rk;
    op_t    op;
    for (int i = 0; i < count; i++) begin
      lo = pick_index();
      inc = ($urandom_range(9) == 0) ? pick_index()
          : field_t'($signed($urandom_range(12)) - 6);
      if ($urandom_range(30) == 0) inc = 0;
      cs = ($urandom_range(7) == 0) ? pick_index() : field_t'($urandom_range(5));
      op = ($urandom_range(15) == 0) ? op_t'($urandom_range(3))
         : op_t'($urandom_range(1));
      rk = ($urandom_range(9) == 0 || cur_threads == 0) ? rank_t'($urandom)
         : rank_t'($urandom_range(cur_threads > 256 ? 255 : cur_threads - 1));
      send(op, rk, lo, lo + field_t'($signed($urandom_range(600)) - 100)
           + (($urandom_range(19) == 0) ? pick_index() : 64'd0), inc, cs);
    end
  endtask

  initial begin
    static cfg_t settings[6] = '{9'd4, 9'd256, 9'd0, 9'd511, 9'd3, 9'd17};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: one thread, zero increment, bad schedule, extreme ranges
    send(OP_BALANCED, 0, 64'd5, 64'd20, 64'd3, 64'd0);
    send(OP_CHUNKED, 0, 64'd20, 64'd5, -64'd2, 64'd0);
    send(OP_SPARE2, 0, 64'd0, 64'd9, 64'd1, 64'd1);
    send(OP_SPARE3, 8'hff, '1, '0, 64'd1, 64'd1);
    send(OP_CHUNKED, 0, 64'd0, 64'd9, 64'd0, 64'd1);
    set_threads(9'd8);
    send(OP_BALANCED, 0, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
         64'd1, 64'd0);
    send(OP_BALANCED, 7, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
         64'd1, 64'd0);
    send(OP_BALANCED, 3, 64'd10, 64'd0, 64'd1, 64'd0);
    send(OP_BALANCED, 5, 64'd0, 64'd3, 64'd1, 64'd0);
    send(OP_BALANCED, 3, 64'd0, 64'd3, 64'd1, 64'd0);
    send(OP_BALANCED, 2, 64'd100, -64'd100, -64'd7, 64'd0);
    send(OP_BALANCED, 8'hff, 64'd0, 64'd1000, 64'd1, 64'd0);
    send(OP_CHUNKED, 1, 64'd0, 64'd99, 64'd1, 64'h8000_0000_0000_0000);
    send(OP_CHUNKED, 2, 64'd0, 64'd99, 64'd2, 64'h7fff_ffff_ffff_ffff);
    send(OP_CHUNKED, 6, 64'd50, 64'd0, 64'd1, 64'd4);
    send(OP_CHUNKED, 3, 64'd0, -64'd99, -64'd3, 64'd5);
    send(OP_SPARE2, 8'haa, {32'h5555_5555, 32'haaaa_aaaa}, '1,
         64'h8000_0000_0000_0000, '1);

    // random phases with changing idling and thread counts
    for (int p = 0; p < 6; p++) begin
      set_threads(settings[p]);
      send_idle = (p < 2) ? 23 : (p < 4) ? 69 : 0;
      recv_idle = (p < 2) ? 69 : (p < 4) ? 23 : 0;
      random_run(215);
    end

    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    $display("sent %0d requests, checked %0d results over six thread counts",
             sent, share_count);
    $display("including 0, 1, 256 and 511 threads and all schedule kinds");
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
